// File: design/cwt_pkg.sv
// shared types and constants for the commutativity witness table
// used by cwt_front, cwt_back and commutativity_witness_table
`default_nettype none
package cwt_pkg;

    localparam int SLOT_COUNT  = 32;
    localparam int KEY_BITS    = 32;
    localparam int KEY_W       = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = 7;

    localparam logic [2:0] KIND_RECORD  = 3'd0;
    localparam logic [2:0] KIND_GC      = 3'd1;
    localparam logic [2:0] KIND_RECOVER = 3'd2;
    localparam logic [2:0] KIND_STOP    = 3'd3;
    localparam logic [2:0] KIND_RESET   = 3'd4;
    localparam logic [2:0] KIND_PROBE   = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_STOPPED      = 3'd1;
    localparam logic [2:0] ST_WRONG_MASTER = 3'd2;
    localparam logic [2:0] ST_NO_SPACE     = 3'd3;
    localparam logic [2:0] ST_KEY_CONFLICT = 3'd4;

    typedef enum logic [2:0] {
        OP_RECORD,
        OP_GC,
        OP_RECOVER,
        OP_STOP,
        OP_RESET,
        OP_PROBE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              master_present;
        logic [31:0]       master_tag;
        logic [63:0]       rpc_id;
        logic [KEY_W-1:0]  key;
        logic [63:0]       client_num;
        logic [31:0]       request_handle;
        logic              batch_last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage
`default_nettype wire

// File: design/cwt_front.sv
// front end: accepts transactions, decodes the kind, holds a two-entry queue
// depends on cwt_pkg
`default_nettype none
module cwt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       kind,
    input  wire logic             master_present,
    input  wire logic [31:0]      master_tag,
    input  wire logic [63:0]      rpc_id,
    input  wire logic [31:0]      key_tag,
    input  wire logic [63:0]      client_num,
    input  wire logic [31:0]      request_handle,
    input  wire logic             batch_last,
    input  wire logic             pop,
    output cwt_pkg::head_t        head,
    output logic                  busy
);

    cwt_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;
    cwt_pkg::item_t in_item;
    cwt_pkg::op_t   op;

    always_comb
    begin
        case (kind)
            cwt_pkg::KIND_RECORD:  op = cwt_pkg::OP_RECORD;
            cwt_pkg::KIND_GC:      op = cwt_pkg::OP_GC;
            cwt_pkg::KIND_RECOVER: op = cwt_pkg::OP_RECOVER;
            cwt_pkg::KIND_STOP:    op = cwt_pkg::OP_STOP;
            cwt_pkg::KIND_RESET:   op = cwt_pkg::OP_RESET;
            cwt_pkg::KIND_PROBE:   op = cwt_pkg::OP_PROBE;
            default:               op = cwt_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        in_item.op             = op;
        in_item.master_present = master_present;
        in_item.master_tag     = master_tag;
        in_item.rpc_id         = rpc_id;
        in_item.key            = key_tag[cwt_pkg::KEY_W-1:0];
        in_item.client_num     = client_num;
        in_item.request_handle = request_handle;
        in_item.batch_last     = batch_last;
    end

    assign busy       = cnt_reg[1];
    assign push       = start && !busy;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/cwt_back.sv
// back end: record table with parallel tag compare, executes queued transactions
// depends on cwt_pkg
`default_nettype none
module cwt_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  cwt_pkg::head_t        head,
    output logic                  pop,
    output logic                  done,
    output logic [2:0]            status,
    output logic [6:0]            dropped_count,
    output logic                  conflict,
    output logic [6:0]            entry_count,
    output logic                  out_valid,
    output logic [63:0]           out_rpc_id,
    output logic [31:0]           out_key_tag,
    output logic [63:0]           out_client_num,
    output logic [31:0]           out_request_handle,
    output logic                  last
);

    localparam int N = cwt_pkg::SLOT_COUNT;

    typedef enum logic [1:0] { S_IDLE, S_MATCH, S_EXEC, S_SCAN } state_t;

    state_t                         state_reg;
    cwt_pkg::item_t                 cur_reg;
    logic [N-1:0]                   valid_reg;
    logic [cwt_pkg::KEY_W-1:0]      key_reg    [N];
    logic [63:0]                    rpc_reg    [N];
    logic [63:0]                    client_reg [N];
    logic [31:0]                    handle_reg [N];
    logic [cwt_pkg::CNT_W-1:0]      count_reg;
    logic                           accepting_reg;
    logic                           bound_reg;
    logic [31:0]                    master_reg;
    logic [cwt_pkg::CNT_W-1:0]      batch_dropped_reg;
    logic                           batch_ok_reg;

    // match results, registered between the compare and execute cycles
    logic                           dup_reg, key_hit_reg, mok_reg;
    logic [N-1:0]                   gc_hit_reg;
    logic [cwt_pkg::IDX_W-1:0]      free_idx_reg;
    logic [cwt_pkg::IDX_W-1:0]      scan_idx_reg;

    logic [N-1:0]                   rpc_match, key_match;
    logic [cwt_pkg::IDX_W-1:0]      free_idx;
    logic                           mok;
    logic                           store;
    logic                           gc_drop;
    logic [cwt_pkg::CNT_W-1:0]      gc_dropped;
    logic                           scan_last;

    logic                           done_reg;
    logic [2:0]                     status_reg;
    logic [6:0]                     dropped_reg;
    logic                           conflict_reg;
    logic [6:0]                     entry_reg;
    logic                           out_valid_reg;
    logic [63:0]                    out_rpc_reg;
    logic [31:0]                    out_key_reg;
    logic [63:0]                    out_client_reg;
    logic [31:0]                    out_handle_reg;
    logic                           last_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rpc_match[i] = valid_reg[i] && (rpc_reg[i] == cur_reg.rpc_id);
            key_match[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
        end
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = cwt_pkg::IDX_W'(i);
            end
        end
        mok = !bound_reg || (cur_reg.master_present && (cur_reg.master_tag == master_reg));
    end

    assign pop   = (state_reg == S_IDLE) && head.valid;
    assign store = (state_reg == S_EXEC) && (cur_reg.op == cwt_pkg::OP_RECORD)
                   && accepting_reg && mok_reg
                   && (count_reg < cwt_pkg::CNT_W'(N)) && !dup_reg && !key_hit_reg;
    assign gc_drop = batch_ok_reg && mok_reg && (gc_hit_reg != '0);
    assign gc_dropped = (gc_drop && batch_dropped_reg != 7'd127)
                        ? batch_dropped_reg + 7'd1 : batch_dropped_reg;
    // no valid slot above the scan position
    assign scan_last = (((valid_reg >> scan_idx_reg) >> 1) == '0);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && head.valid)
        begin
            cur_reg <= head.item;
        end
        if (store)
        begin
            key_reg[free_idx_reg]    <= cur_reg.key;
            rpc_reg[free_idx_reg]    <= cur_reg.rpc_id;
            client_reg[free_idx_reg] <= cur_reg.client_num;
            handle_reg[free_idx_reg] <= cur_reg.request_handle;
        end
        if (state_reg == S_MATCH)
        begin
            dup_reg      <= (rpc_match != '0);
            key_hit_reg  <= (key_match != '0);
            gc_hit_reg   <= rpc_match & key_match;
            free_idx_reg <= free_idx;
            mok_reg      <= mok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            valid_reg         <= '0;
            count_reg         <= '0;
            accepting_reg     <= 1'b1;
            bound_reg         <= 1'b0;
            master_reg        <= '0;
            batch_dropped_reg <= '0;
            batch_ok_reg      <= 1'b1;
            scan_idx_reg      <= '0;
            done_reg          <= 1'b0;
            status_reg        <= '0;
            dropped_reg       <= '0;
            conflict_reg      <= 1'b0;
            entry_reg         <= '0;
            out_valid_reg     <= 1'b0;
            out_rpc_reg       <= '0;
            out_key_reg       <= '0;
            out_client_reg    <= '0;
            out_handle_reg    <= '0;
            last_reg          <= 1'b0;
        end
        else
        begin
            done_reg       <= 1'b0;
            status_reg     <= cwt_pkg::ST_OK;
            dropped_reg    <= '0;
            conflict_reg   <= 1'b0;
            entry_reg      <= count_reg;
            out_valid_reg  <= 1'b0;
            out_rpc_reg    <= '0;
            out_key_reg    <= '0;
            out_client_reg <= '0;
            out_handle_reg <= '0;
            last_reg       <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    case (cur_reg.op)
                        cwt_pkg::OP_RECORD:
                        begin
                            if (!accepting_reg)
                                status_reg <= cwt_pkg::ST_STOPPED;
                            else if (!mok_reg)
                                status_reg <= cwt_pkg::ST_WRONG_MASTER;
                            else if (count_reg >= cwt_pkg::CNT_W'(N))
                                status_reg <= cwt_pkg::ST_NO_SPACE;
                            else if (!dup_reg && key_hit_reg)
                                status_reg <= cwt_pkg::ST_KEY_CONFLICT;
                            if (store)
                            begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                count_reg <= count_reg + 7'd1;
                                entry_reg <= count_reg + 7'd1;
                                if (!bound_reg && cur_reg.master_present)
                                begin
                                    bound_reg  <= 1'b1;
                                    master_reg <= cur_reg.master_tag;
                                end
                            end
                        end
                        cwt_pkg::OP_GC:
                        begin
                            if (!(batch_ok_reg && mok_reg))
                            begin
                                status_reg <= cwt_pkg::ST_WRONG_MASTER;
                            end
                            if (gc_drop)
                            begin
                                valid_reg <= valid_reg & ~gc_hit_reg;
                                count_reg <= count_reg - 7'd1;
                                entry_reg <= count_reg - 7'd1;
                            end
                            dropped_reg <= gc_dropped;
                            // the last entry of a batch reopens the next batch
                            if (cur_reg.batch_last)
                            begin
                                batch_dropped_reg <= '0;
                                batch_ok_reg      <= 1'b1;
                            end
                            else
                            begin
                                batch_dropped_reg <= gc_dropped;
                                batch_ok_reg      <= batch_ok_reg && mok_reg;
                            end
                        end
                        cwt_pkg::OP_RECOVER:
                        begin
                            if (!mok_reg)
                            begin
                                status_reg <= cwt_pkg::ST_WRONG_MASTER;
                            end
                            else
                            begin
                                accepting_reg <= 1'b0;
                                if (count_reg != '0)
                                begin
                                    done_reg     <= 1'b0;
                                    scan_idx_reg <= '0;
                                    state_reg    <= S_SCAN;
                                end
                            end
                        end
                        cwt_pkg::OP_STOP:
                        begin
                            accepting_reg <= 1'b0;
                        end
                        cwt_pkg::OP_RESET:
                        begin
                            valid_reg         <= '0;
                            count_reg         <= '0;
                            entry_reg         <= '0;
                            accepting_reg     <= 1'b1;
                            bound_reg         <= cur_reg.master_present;
                            master_reg        <= cur_reg.master_present
                                                 ? cur_reg.master_tag : 32'd0;
                            batch_dropped_reg <= '0;
                            batch_ok_reg      <= 1'b1;
                        end
                        cwt_pkg::OP_PROBE:
                        begin
                            conflict_reg <= key_hit_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // one slot per cycle, empty slots are skipped silently
                    if (valid_reg[scan_idx_reg])
                    begin
                        done_reg       <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        out_rpc_reg    <= rpc_reg[scan_idx_reg];
                        out_key_reg    <= 32'(key_reg[scan_idx_reg]);
                        out_client_reg <= client_reg[scan_idx_reg];
                        out_handle_reg <= handle_reg[scan_idx_reg];
                        last_reg       <= scan_last;
                        if (scan_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    scan_idx_reg <= scan_idx_reg + cwt_pkg::IDX_W'(1);
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign dropped_count      = dropped_reg;
    assign conflict           = conflict_reg;
    assign entry_count        = entry_reg;
    assign out_valid          = out_valid_reg;
    assign out_rpc_id         = out_rpc_reg;
    assign out_key_tag        = out_key_reg;
    assign out_client_num     = out_client_reg;
    assign out_request_handle = out_handle_reg;
    assign last               = last_reg;

endmodule
`default_nettype wire

// File: design/commutativity_witness_table.sv
// top level of the commutativity witness table: front queue and back executor
// depends on cwt_pkg, cwt_front, cwt_back
//
// channel   signals                       transfer
// command   start, busy, kind .. last     start && !busy at a rising edge
// result    done, status .. last          done high for one cycle, no stall
//
// each transaction goes through these steps in the back end once it leaves the queue
// (dequeue, parallel tag compare over all slots, execute); recovery then walks
// the slots one per cycle, up to the highest valid slot.
// busy rises when the two-entry queue is full. reset empties the table and queue.
// results cannot be held off: each shows for exactly one cycle with done.
`default_nettype none
module commutativity_witness_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [2:0]   kind,
    input  wire logic         master_present,
    input  wire logic [31:0]  master_tag,
    input  wire logic [63:0]  rpc_id,
    input  wire logic [31:0]  key_tag,
    input  wire logic [63:0]  client_num,
    input  wire logic [31:0]  request_handle,
    input  wire logic         batch_last,
    output logic              done,
    output logic [2:0]        status,
    output logic [6:0]        dropped_count,
    output logic              conflict,
    output logic [6:0]        entry_count,
    output logic              out_valid,
    output logic [63:0]       out_rpc_id,
    output logic [31:0]       out_key_tag,
    output logic [63:0]       out_client_num,
    output logic [31:0]       out_request_handle,
    output logic              last
);

    cwt_pkg::head_t head;
    logic           pop;

    cwt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .kind           (kind),
        .master_present (master_present),
        .master_tag     (master_tag),
        .rpc_id         (rpc_id),
        .key_tag        (key_tag),
        .client_num     (client_num),
        .request_handle (request_handle),
        .batch_last     (batch_last),
        .pop            (pop),
        .head           (head),
        .busy           (busy)
    );

    cwt_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .pop                (pop),
        .done               (done),
        .status             (status),
        .dropped_count      (dropped_count),
        .conflict           (conflict),
        .entry_count        (entry_count),
        .out_valid          (out_valid),
        .out_rpc_id         (out_rpc_id),
        .out_key_tag        (out_key_tag),
        .out_client_num     (out_client_num),
        .out_request_handle (out_request_handle),
        .last               (last)
    );

endmodule
`default_nettype wire

// File: tb/cwt_checker.sv
// predictor and result checker for the commutativity witness table
// depends on cwt_pkg; watches the command and result ports beside the block
`default_nettype none
module cwt_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire logic [2:0]   kind,
    input  wire logic         master_present,
    input  wire logic [31:0]  master_tag,
    input  wire logic [63:0]  rpc_id,
    input  wire logic [31:0]  key_tag,
    input  wire logic [63:0]  client_num,
    input  wire logic [31:0]  request_handle,
    input  wire logic         batch_last,
    input  wire logic         done,
    input  wire logic [2:0]   status,
    input  wire logic [6:0]   dropped_count,
    input  wire logic         conflict,
    input  wire logic [6:0]   entry_count,
    input  wire logic         out_valid,
    input  wire logic [63:0]  out_rpc_id,
    input  wire logic [31:0]  out_key_tag,
    input  wire logic [63:0]  out_client_num,
    input  wire logic [31:0]  out_request_handle,
    input  wire logic         last,
    output int                fail_count,
    output int                pending,
    output int                result_total,
    output int                recovered_total
);

    typedef struct packed {
        logic [2:0]  st;
        logic [6:0]  dropped;
        logic        hit;
        logic [6:0]  held;
        logic        has_rec;
        logic [63:0] rpc;
        logic [31:0] key;
        logic [63:0] client;
        logic [31:0] handle;
        logic        fin;
    } outcome_t;

    outcome_t expected_q[$];

    logic        held_valid [cwt_pkg::SLOT_COUNT];
    logic [31:0] held_key   [cwt_pkg::SLOT_COUNT];
    logic [63:0] held_rpc   [cwt_pkg::SLOT_COUNT];
    logic [63:0] held_client[cwt_pkg::SLOT_COUNT];
    logic [31:0] held_handle[cwt_pkg::SLOT_COUNT];
    logic        open_for_records;
    logic        owner_bound;
    logic [31:0] owner_tag;
    logic [6:0]  batch_drops;
    logic        batch_owner_ok;

    function automatic int held_total();
        int n;
        n = 0;
        for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
            if (held_valid[i]) n++;
        return n;
    endfunction

    function automatic int slot_of_key(logic [31:0] k);
        for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
            if (held_valid[i] && held_key[i] == k) return i;
        return -1;
    endfunction

    function automatic logic owner_matches(logic present, logic [31:0] tag);
        return !owner_bound || (present && tag == owner_tag);
    endfunction

    task automatic push_outcome(logic [2:0] st, logic [6:0] dr, logic hit, int slot,
                                logic fin);
        outcome_t o;
        o = '0;
        o.st = st;
        o.dropped = dr;
        o.hit = hit;
        o.held = 7'(held_total());
        if (slot >= 0) begin
            o.has_rec = 1'b1;
            o.rpc = held_rpc[slot];
            o.key = held_key[slot];
            o.client = held_client[slot];
            o.handle = held_handle[slot];
        end
        o.fin = fin;
        expected_q.insert(expected_q.size(), o);
    endtask

    task automatic clear_slots();
        for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
        begin
            held_valid[i] = 1'b0;
            held_key[i] = '0;
            held_rpc[i] = '0;
            held_client[i] = '0;
            held_handle[i] = '0;
        end
    endtask

    task automatic predict_transaction();
        logic [2:0]  st;
        logic        dup;
        int          s;
        int          top_slot;
        logic [31:0] kt;
        st = cwt_pkg::ST_OK;
        dup = 1'b0;
        s = -1;
        top_slot = -1;
        // only the low key bits take part in compares
        kt = 32'(key_tag[cwt_pkg::KEY_W-1:0]);
        case (kind)
            cwt_pkg::KIND_RECORD:
            begin
                if (!open_for_records) st = cwt_pkg::ST_STOPPED;
                else if (!owner_matches(master_present, master_tag))
                    st = cwt_pkg::ST_WRONG_MASTER;
                else if (held_total() >= cwt_pkg::SLOT_COUNT) st = cwt_pkg::ST_NO_SPACE;
                else
                begin
                    for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
                        if (held_valid[i] && held_rpc[i] == rpc_id) dup = 1'b1;
                    if (!dup)
                    begin
                        if (slot_of_key(kt) >= 0) st = cwt_pkg::ST_KEY_CONFLICT;
                        else
                        begin
                            for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
                                if (!held_valid[i] && s < 0) s = i;
                            held_valid[s] = 1'b1;
                            held_key[s] = kt;
                            held_rpc[s] = rpc_id;
                            held_client[s] = client_num;
                            held_handle[s] = request_handle;
                            if (!owner_bound && master_present)
                            begin
                                owner_bound = 1'b1;
                                owner_tag = master_tag;
                            end
                        end
                    end
                end
                push_outcome(st, '0, 1'b0, -1, 1'b1);
            end
            cwt_pkg::KIND_GC:
            begin
                if (batch_owner_ok && owner_matches(master_present, master_tag))
                begin
                    s = slot_of_key(kt);
                    if (s >= 0 && held_rpc[s] == rpc_id)
                    begin
                        held_valid[s] = 1'b0;
                        if (batch_drops < 7'd127) batch_drops++;
                    end
                end
                else
                begin
                    batch_owner_ok = 1'b0;
                    st = cwt_pkg::ST_WRONG_MASTER;
                end
                push_outcome(st, batch_drops, 1'b0, -1, 1'b1);
                if (batch_last)
                begin
                    batch_drops = '0;
                    batch_owner_ok = 1'b1;
                end
            end
            cwt_pkg::KIND_RECOVER:
            begin
                if (!owner_matches(master_present, master_tag))
                    push_outcome(cwt_pkg::ST_WRONG_MASTER, '0, 1'b0, -1, 1'b1);
                else
                begin
                    open_for_records = 1'b0;
                    for (int i = 0; i < cwt_pkg::SLOT_COUNT; i++)
                        if (held_valid[i]) top_slot = i;
                    if (top_slot < 0) push_outcome(cwt_pkg::ST_OK, '0, 1'b0, -1, 1'b1);
                    for (int i = 0; i <= top_slot; i++)
                        if (held_valid[i])
                            push_outcome(cwt_pkg::ST_OK, '0, 1'b0, i, i == top_slot);
                end
            end
            cwt_pkg::KIND_STOP:
            begin
                open_for_records = 1'b0;
                push_outcome(cwt_pkg::ST_OK, '0, 1'b0, -1, 1'b1);
            end
            cwt_pkg::KIND_RESET:
            begin
                clear_slots();
                open_for_records = 1'b1;
                owner_bound = master_present;
                owner_tag = master_present ? master_tag : '0;
                batch_drops = '0;
                batch_owner_ok = 1'b1;
                push_outcome(cwt_pkg::ST_OK, '0, 1'b0, -1, 1'b1);
            end
            cwt_pkg::KIND_PROBE:
                push_outcome(cwt_pkg::ST_OK, '0, slot_of_key(kt) >= 0, -1, 1'b1);
            default:
                push_outcome(cwt_pkg::ST_OK, '0, 1'b0, -1, 1'b1);
        endcase
    endtask

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s at %0t: expected %h got %h", what, $realtime,
                     exp_v, act_v);
    endtask

    task automatic check_result();
        outcome_t e;
        if (expected_q.size() == 0)
        begin
            report("unexpected result", '0, 64'(status));
            return;
        end
        e = expected_q.pop_front();
        if (status !== e.st) report("status", 64'(e.st), 64'(status));
        if (dropped_count !== e.dropped) report("dropped_count", 64'(e.dropped),
                                                64'(dropped_count));
        if (conflict !== e.hit) report("conflict", 64'(e.hit), 64'(conflict));
        if (entry_count !== e.held) report("entry_count", 64'(e.held), 64'(entry_count));
        if (out_valid !== e.has_rec) report("out_valid", 64'(e.has_rec), 64'(out_valid));
        if (out_rpc_id !== e.rpc) report("out_rpc_id", e.rpc, out_rpc_id);
        if (out_key_tag !== e.key) report("out_key_tag", 64'(e.key), 64'(out_key_tag));
        if (out_client_num !== e.client) report("out_client_num", e.client, out_client_num);
        if (out_request_handle !== e.handle) report("out_request_handle", 64'(e.handle),
                                                    64'(out_request_handle));
        if (last !== e.fin) report("last", 64'(e.fin), 64'(last));
        if (e.has_rec) recovered_total++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        result_total = 0;
        recovered_total = 0;
        clear_slots();
        open_for_records = 1'b1;
        owner_bound = 1'b0;
        owner_tag = '0;
        batch_drops = '0;
        batch_owner_ok = 1'b1;
    end

    // results are checked before the transaction of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                result_total++;
                check_result();
            end
            if (start && !busy) predict_transaction();
        end
        pending = expected_q.size();
    end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// stimulus and verdict for the commutativity witness table
// depends on cwt_pkg, commutativity_witness_table and cwt_checker
`default_nettype none
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic        master_present;
    logic [31:0] master_tag;
    logic [63:0] rpc_id;
    logic [31:0] key_tag;
    logic [63:0] client_num;
    logic [31:0] request_handle;
    logic        batch_last;
    logic        done;
    logic [2:0]  status;
    logic [6:0]  dropped_count;
    logic        conflict;
    logic [6:0]  entry_count;
    logic        out_valid;
    logic [63:0] out_rpc_id;
    logic [31:0] out_key_tag;
    logic [63:0] out_client_num;
    logic [31:0] out_request_handle;
    logic        last;
    int          fail_count;
    int          pending;
    int          result_total;
    int          recovered_total;

    // bookkeeping of what the stimulus has stored, for hitting gc and dup cases
    logic [31:0] cur_owner;
    logic [31:0] stored_key[$];
    logic [63:0] stored_rpc[$];
    int          sent;

    commutativity_witness_table u_dut (.*);

    cwt_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // start drops only when a real gap follows
    task automatic idle_gap();
        int n;
        n = 0;
        if ($urandom_range(0, 99) < 30)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(logic [2:0] k, logic mp, logic [31:0] mt, logic [63:0] rpc,
                        logic [31:0] key, logic [63:0] cl, logic [31:0] h, logic bl);
        start <= 1'b1;
        kind <= k;
        master_present <= mp;
        master_tag <= mt;
        rpc_id <= rpc;
        key_tag <= key;
        client_num <= cl;
        request_handle <= h;
        batch_last <= bl;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
        if (k == cwt_pkg::KIND_RECORD)
        begin
            stored_key = {stored_key, key};
            stored_rpc = {stored_rpc, rpc};
        end
        if (k == cwt_pkg::KIND_RESET)
        begin
            stored_key.delete();
            stored_rpc.delete();
        end
        if ($urandom_range(0, 99) < 40)
        begin
            idle_gap();
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_record(logic [31:0] owner);
        logic [31:0] key;
        logic [63:0] rpc;
        key = (stored_key.size() > 0 && $urandom_range(0, 9) == 0)
              ? stored_key[$urandom_range(0, stored_key.size() - 1)] : $urandom;
        rpc = (stored_rpc.size() > 0 && $urandom_range(0, 9) == 0)
              ? stored_rpc[$urandom_range(0, stored_rpc.size() - 1)]
              : {$urandom, $urandom};
        send(cwt_pkg::KIND_RECORD, $urandom_range(0, 19) != 0,
             ($urandom_range(0, 19) == 0) ? $urandom : owner,
             rpc, key, {$urandom, $urandom}, $urandom, 1'b0);
    endtask

    task automatic send_gc(logic [31:0] owner, logic bl);
        int j;
        j = stored_key.size() > 0 ? $urandom_range(0, stored_key.size() - 1) : 0;
        if (stored_key.size() > 0 && $urandom_range(0, 4) != 0)
            send(cwt_pkg::KIND_GC, 1'b1, ($urandom_range(0, 14) == 0) ? $urandom : owner,
                 ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : stored_rpc[j],
                 stored_key[j], {$urandom, $urandom}, $urandom, bl);
        else
            send(cwt_pkg::KIND_GC, 1'($urandom_range(0, 1)), owner, {$urandom, $urandom},
                 $urandom, {$urandom, $urandom}, $urandom, bl);
    endtask

    initial
    begin
        int pick;
        int len;
        int j;
        rst_n = 1'b0;
        start = 1'b0;
        kind = cwt_pkg::KIND_RECORD;
        master_present = 1'b0;
        master_tag = '0;
        rpc_id = '0;
        key_tag = '0;
        client_num = '0;
        request_handle = '0;
        batch_last = 1'b0;
        sent = 0;
        cur_owner = 32'hFFFF_FFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every kind, master rules, dup, conflict, full table
        send(cwt_pkg::KIND_PROBE, 1'b0, '0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECOVER, 1'b0, '0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RESET, 1'b0, '0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b0, '0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b1, '1, '1, '1, '1, '1, 1'b1);
        send(cwt_pkg::KIND_RECORD, 1'b1, '1, '1, 32'h1, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b1, '1, 64'h5, '1, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b1, 32'h0, 64'h6, 32'h6, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b0, '1, 64'h7, 32'h7, '0, '0, 1'b0);
        send(cwt_pkg::KIND_PROBE, 1'b0, '0, '0, '1, '0, '0, 1'b0);
        send(cwt_pkg::KIND_GC, 1'b1, 32'h0, '1, '1, '0, '0, 1'b0);
        send(cwt_pkg::KIND_GC, 1'b1, '1, '1, '1, '0, '0, 1'b1);
        send(cwt_pkg::KIND_GC, 1'b1, '1, '0, '0, '0, '0, 1'b1);
        send(cwt_pkg::KIND_RECOVER, 1'b1, 32'h0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECOVER, 1'b1, '1, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RECORD, 1'b1, '1, 64'h9, 32'h9, '0, '0, 1'b0);
        send(3'd6, 1'b1, '1, '1, '1, '1, '1, 1'b1);
        send(3'd7, 1'b0, '0, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_RESET, 1'b1, 32'hA5A5_5A5A, '0, '0, '0, '0, 1'b0);
        for (int i = 0; i < cwt_pkg::SLOT_COUNT + 1; i++)
            send(cwt_pkg::KIND_RECORD, 1'b1, 32'hA5A5_5A5A, 64'(i + 100), 32'(i + 100),
                 64'(i), 32'(i), 1'b0);
        send(cwt_pkg::KIND_RECOVER, 1'b1, 32'hA5A5_5A5A, '0, '0, '0, '0, 1'b0);
        send(cwt_pkg::KIND_STOP, 1'b0, '0, '0, '0, '0, '0, 1'b0);

        // random: sessions of reset, records, gc batches, probes, stops, unused kinds, recovery
        while (sent < 310)
        begin
            cur_owner = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
            send(cwt_pkg::KIND_RESET, $urandom_range(0, 7) != 0, cur_owner,
                 {$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                 1'($urandom_range(0, 1)));
            len = $urandom_range(3, 20);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55) send_record(cur_owner);
                else if (pick < 75)
                begin
                    j = $urandom_range(1, 4);
                    for (int b = 0; b < j; b++) send_gc(cur_owner, b == j - 1);
                end
                else if (pick < 88)
                    send(cwt_pkg::KIND_PROBE, 1'($urandom_range(0, 1)), $urandom,
                         {$urandom, $urandom},
                         (stored_key.size() > 0 && pick[0])
                         ? stored_key[$urandom_range(0, stored_key.size() - 1)] : $urandom,
                         {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)));
                else if (pick < 92)
                    send(cwt_pkg::KIND_STOP, 1'($urandom_range(0, 1)), $urandom,
                         {$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                         1'($urandom_range(0, 1)));
                else
                    send(3'($urandom_range(6, 7)), 1'($urandom_range(0, 1)), $urandom,
                         {$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                         1'($urandom_range(0, 1)));
            end
            send(cwt_pkg::KIND_RECOVER, $urandom_range(0, 9) != 0,
                 ($urandom_range(0, 9) == 0) ? $urandom : cur_owner,
                 '0, '0, '0, '0, 1'b0);
            if ($urandom_range(0, 3) == 0) send_record(cur_owner);
        end

        wait_drain();
        $display("sent %0d commands, checked %0d results, %0d recovered records",
                 sent, result_total, recovered_total);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
